/* rtl/pid_ctl_pkg.sv */
`default_nettype none

package pid_ctl_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned AddrW = 5;
  localparam int unsigned BusW  = 32;

  typedef logic signed [DataW-1:0] q88_t;
  typedef logic        [DataW-1:0] gain_t;
  typedef logic        [2:0]       reg_idx_t;

  localparam reg_idx_t REG_PROP_GAIN      = 3'd0;
  localparam reg_idx_t REG_INTEG_GAIN     = 3'd1;
  localparam reg_idx_t REG_DERIV_GAIN     = 3'd2;
  localparam reg_idx_t REG_OUT_LOW        = 3'd3;
  localparam reg_idx_t REG_OUT_HIGH       = 3'd4;
  localparam reg_idx_t REG_PERIOD_TICKS   = 3'd5;
  localparam reg_idx_t REG_REVERSE_ACTING = 3'd6;
  localparam reg_idx_t REG_AUTO_MODE      = 3'd7;

  localparam gain_t PROP_GAIN_RST   = 16'd256;
  localparam gain_t INTEG_GAIN_RST  = 16'd0;
  localparam gain_t DERIV_GAIN_RST  = 16'd0;
  localparam q88_t  OUT_LOW_RST     = -16'sd2560;
  localparam q88_t  OUT_HIGH_RST    = 16'sd25600;
  localparam gain_t PERIOD_RST      = 16'd1000;
  localparam gain_t TICKS_SAT       = 16'hFFFF;

  // Half of one Q8.8 LSB of a Q16.16 product, for round half up.
  localparam logic signed [33:0] ROUND_HALF = 34'sd128;

endpackage

`default_nettype wire

/* rtl/pid_controller_step.sv */
`default_nettype none
// Sampled PID regulator, Q8.8 fixed point.
// Input channel (in_valid/in_ready): one tick per request carrying measurement,
// target and manual value. Result channel (out_valid/out_ready): one drive value,
// given only on ticks that run an update (auto mode, first auto tick or period
// elapsed). Manual-mode ticks and in-between ticks produce no result.
// An accepted tick is held in the input register and its result is loaded into
// the output register, which raises out_valid. Throughput: one tick per cycle
// unless an updating tick finds the output register still full; the three 17x17
// gain products, the adds and the two clamps all sit in the single stage after
// the input register. When the receiver stalls, a pending result is held; ticks
// that give no result keep flowing, and a tick that needs to update waits in the
// input register, with in_ready low, until the output register frees.
// Configuration: APB-style writes at byte address 4*index, pready always high;
// write only while no tick is in flight.
// Reset (synchronous, rst_n low) loads the register defaults, clears the
// integral, previous measurement, held output and auto flag, and saturates the
// tick counter so the next auto tick updates. No clearing pass is needed.
module pid_controller_step
  import pid_ctl_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire signed [15:0]    in_measurement,
  input  wire signed [15:0]    in_target,
  input  wire signed [15:0]    in_manual_value,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic signed [15:0]   out_drive,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [AddrW-1:0]      paddr,
  input  wire [BusW-1:0]       pwdata,
  output logic [BusW-1:0]      prdata,
  output logic                 pready
);

  // Configuration registers.
  gain_t prop_gain_r, integ_gain_r, deriv_gain_r, period_r;
  q88_t  out_low_r, out_high_r;
  logic  reverse_r, auto_mode_r;

  // Controller state.
  q88_t  integ_sum_r, prev_meas_r, held_drive_r;
  gain_t ticks_r;
  logic  was_auto_r;

  // Input register and output register.
  logic  s1_vld_r;
  q88_t  s1_meas_r, s1_tgt_r, s1_man_r;
  logic  out_valid_r;
  q88_t  out_drive_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_PROP_GAIN:      prdata = {16'd0, prop_gain_r};
      REG_INTEG_GAIN:     prdata = {16'd0, integ_gain_r};
      REG_DERIV_GAIN:     prdata = {16'd0, deriv_gain_r};
      REG_OUT_LOW:        prdata = {16'd0, out_low_r};
      REG_OUT_HIGH:       prdata = {16'd0, out_high_r};
      REG_PERIOD_TICKS:   prdata = {16'd0, period_r};
      REG_REVERSE_ACTING: prdata = {31'd0, reverse_r};
      REG_AUTO_MODE:      prdata = {31'd0, auto_mode_r};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      out_low_r    <= OUT_LOW_RST;
      out_high_r   <= OUT_HIGH_RST;
      period_r     <= PERIOD_RST;
      reverse_r    <= 1'b0;
      auto_mode_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:      prop_gain_r  <= pwdata[15:0];
        REG_INTEG_GAIN:     integ_gain_r <= pwdata[15:0];
        REG_DERIV_GAIN:     deriv_gain_r <= pwdata[15:0];
        REG_OUT_LOW:        out_low_r    <= pwdata[15:0];
        REG_OUT_HIGH:       out_high_r   <= pwdata[15:0];
        REG_PERIOD_TICKS:   period_r     <= pwdata[15:0];
        REG_REVERSE_ACTING: reverse_r    <= pwdata[0];
        REG_AUTO_MODE:      auto_mode_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Clamp order matters with crossed limits: the upper limit is tested first.
  function automatic q88_t clamp_lim(input logic signed [27:0] x,
                                     input q88_t lo, input q88_t hi);
    logic signed [27:0] lo_w, hi_w;
    lo_w = 28'(lo);
    hi_w = 28'(hi);
    if (x > hi_w)      clamp_lim = hi;
    else if (x < lo_w) clamp_lim = lo;
    else               clamp_lim = x[15:0];
  endfunction

  function automatic logic signed [25:0] round_q88(input logic signed [16:0] k,
                                                   input logic signed [16:0] v);
    logic signed [33:0] prod;
    logic signed [33:0] sum;
    prod = k * v;
    sum  = prod + ROUND_HALF;
    round_q88 = sum[33:8];
  endfunction

  function automatic logic signed [16:0] signed_gain(input gain_t g, input logic neg);
    logic signed [16:0] gs;
    gs = $signed({1'b0, g});
    signed_gain = neg ? -gs : gs;
  endfunction

  gain_t ticks_inc, ticks_nxt;
  logic  first, upd, out_free, s1_go;
  q88_t  integ_base, prev_eff, integ_c, drive_c;
  logic signed [16:0] kp_s, ki_s, kd_s, err, delta;
  logic signed [25:0] rp, ri, rd;
  logic signed [27:0] integ_raw, drive_raw;

  always_comb begin
    ticks_inc  = (ticks_r == TICKS_SAT) ? ticks_r : ticks_r + 16'd1;
    first      = auto_mode_r && !was_auto_r;
    upd        = s1_vld_r && auto_mode_r && (first || (ticks_inc >= period_r));
    out_free   = !out_valid_r || out_ready;
    s1_go      = s1_vld_r && (!upd || out_free);
    in_ready   = !s1_vld_r || s1_go;
    ticks_nxt  = upd ? '0 : ticks_inc;

    // A bumpless start takes the held output as the integral and the current
    // measurement as the previous one; a previous value of zero is also replaced.
    integ_base = first ? held_drive_r : integ_sum_r;
    prev_eff   = (first || (prev_meas_r == '0)) ? s1_meas_r : prev_meas_r;

    kp_s  = signed_gain(prop_gain_r, reverse_r);
    ki_s  = signed_gain(integ_gain_r, reverse_r);
    kd_s  = signed_gain(deriv_gain_r, reverse_r);
    err   = 17'(s1_tgt_r) - 17'(s1_meas_r);
    delta = 17'(s1_meas_r) - 17'(prev_eff);

    rp = round_q88(kp_s, err);
    ri = round_q88(ki_s, err);
    rd = round_q88(kd_s, delta);

    integ_raw = 28'(integ_base) + 28'(ri);
    integ_c   = clamp_lim(integ_raw, out_low_r, out_high_r);
    // Derivative on measurement is subtracted.
    drive_raw = 28'(rp) + 28'(integ_c) - 28'(rd);
    drive_c   = clamp_lim(drive_raw, out_low_r, out_high_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_meas_r <= in_measurement;
      s1_tgt_r  <= in_target;
      s1_man_r  <= in_manual_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_sum_r  <= '0;
      prev_meas_r  <= '0;
      held_drive_r <= '0;
      ticks_r      <= TICKS_SAT;
      was_auto_r   <= 1'b0;
    end else if (s1_go) begin
      ticks_r <= ticks_nxt;
      if (!auto_mode_r) begin
        held_drive_r <= s1_man_r;
        was_auto_r   <= 1'b0;
      end else if (upd) begin
        integ_sum_r  <= integ_c;
        held_drive_r <= drive_c;
        prev_meas_r  <= s1_meas_r;
        was_auto_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && upd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && upd) begin
      out_drive_r <= drive_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

`ifndef SYNTHESIS
  a_upd_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && upd |=> out_valid_r && (ticks_r == '0))
    else $error("update did not load result or restart tick count");

  a_manual_clears_auto: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !auto_mode_r |=> !was_auto_r && (held_drive_r == $past(s1_man_r)))
    else $error("manual tick did not hold manual value");

  a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && upd && (out_low_r <= out_high_r) |=>
      (out_drive_r >= $past(out_low_r)) && (out_drive_r <= $past(out_high_r)))
    else $error("drive outside limits");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_go |-> !in_ready && upd && out_valid_r)
    else $error("input register stalled without a pending result");
`endif

endmodule

`default_nettype wire

/* sim/pid_ctl_checker.sv */
`default_nettype none

module pid_ctl_checker
  import pid_ctl_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  wire signed [15:0]  in_measurement,
  input  wire signed [15:0]  in_target,
  input  wire signed [15:0]  in_manual_value,
  input  wire                out_valid,
  input  wire                out_ready,
  input  wire signed [15:0]  out_drive,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire                pready,
  input  wire [AddrW-1:0]    paddr,
  input  wire [BusW-1:0]     pwdata,
  output int                 n_fail,
  output int                 n_pending,
  output int                 n_ticks,
  output int                 n_drives
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the register file.
  gain_t kp_reg, ki_reg, kd_reg, period_reg;
  q88_t  lim_lo, lim_hi;
  logic  reverse_reg, auto_reg;

  // Controller state as it should be after every accepted request.
  q88_t        integ_acc, last_meas, hold_val;
  logic [15:0] tick_count;
  logic        auto_seen;

  q88_t drive_q[$];

  initial begin
    n_fail = 0;
    n_pending = 0;
    n_ticks = 0;
    n_drives = 0;
  end

  function automatic longint limit_clamp(longint x);
    longint lo, hi;
    lo = lim_lo;
    hi = lim_hi;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Gain times difference is Q16.16; round half up back to Q8.8.
  function automatic longint scaled(longint g, longint v);
    return (g * v + 128) >>> 8;
  endfunction

  task automatic take_tick(q88_t meas, q88_t tgt, q88_t man);
    logic   fresh_start;
    longint kp, ki, kd, err, dlt, integ, drv;
    fresh_start = 1'b0;
    if (tick_count != TICKS_SAT) tick_count++;
    if (!auto_reg) begin
      hold_val = man;
      auto_seen = 1'b0;
      return;
    end
    if (!auto_seen) begin
      // Bumpless start: the integral takes the held output before it is clamped.
      integ_acc = hold_val;
      last_meas = meas;
      hold_val = q88_t'(limit_clamp(longint'(hold_val)));
      auto_seen = 1'b1;
      fresh_start = 1'b1;
    end
    if (!fresh_start && tick_count < period_reg) return;
    kp = kp_reg;
    ki = ki_reg;
    kd = kd_reg;
    if (reverse_reg) begin
      kp = -kp;
      ki = -ki;
      kd = -kd;
    end
    if (last_meas == 0) last_meas = meas;
    err = longint'(tgt) - longint'(meas);
    dlt = longint'(meas) - longint'(last_meas);
    integ = limit_clamp(longint'(integ_acc) + scaled(ki, err));
    drv = limit_clamp(scaled(kp, err) + integ - scaled(kd, dlt));
    integ_acc = q88_t'(integ);
    hold_val = q88_t'(drv);
    last_meas = meas;
    tick_count = '0;
    drive_q.push_back(q88_t'(drv));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kp_reg = PROP_GAIN_RST;
      ki_reg = INTEG_GAIN_RST;
      kd_reg = DERIV_GAIN_RST;
      lim_lo = OUT_LOW_RST;
      lim_hi = OUT_HIGH_RST;
      period_reg = PERIOD_RST;
      reverse_reg = 1'b0;
      auto_reg = 1'b0;
      integ_acc = '0;
      last_meas = '0;
      hold_val = '0;
      tick_count = TICKS_SAT;
      auto_seen = 1'b0;
      drive_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[AddrW-1:2]))
          REG_PROP_GAIN:      kp_reg = pwdata[15:0];
          REG_INTEG_GAIN:     ki_reg = pwdata[15:0];
          REG_DERIV_GAIN:     kd_reg = pwdata[15:0];
          REG_OUT_LOW:        lim_lo = q88_t'(pwdata[15:0]);
          REG_OUT_HIGH:       lim_hi = q88_t'(pwdata[15:0]);
          REG_PERIOD_TICKS:   period_reg = pwdata[15:0];
          REG_REVERSE_ACTING: reverse_reg = pwdata[0];
          REG_AUTO_MODE:      auto_reg = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        n_ticks++;
        take_tick(in_measurement, in_target, in_manual_value);
      end
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          n_fail++;
          $display("%0t: drive %0d arrived with no request pending", $time, out_drive);
        end else begin
          n_drives++;
          if (out_drive !== drive_q[0]) begin
            n_fail++;
            $display("%0t: drive expected %0d, got %0d", $time, drive_q[0], out_drive);
          end
          void'(drive_q.pop_front());
        end
      end
    end
    n_pending = drive_q.size();
  end

endmodule

`default_nettype wire

/* sim/pid_controller_step_tb.sv */
`default_nettype none

module pid_controller_step_tb
  import pid_ctl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_TICKS = 700;
  localparam int HOLD_CYCLES  = 80;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  wire               in_ready;
  logic signed [15:0] in_measurement = '0;
  logic signed [15:0] in_target = '0;
  logic signed [15:0] in_manual_value = '0;
  wire               out_valid;
  logic              out_ready = 1'b0;
  wire signed [15:0] out_drive;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [BusW-1:0]   pwdata = '0;
  wire  [BusW-1:0]   prdata;
  wire               pready;

  int n_fail, n_pending, n_ticks, n_drives;
  int random_sent = 0;
  int settings_used = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pid_controller_step uut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_measurement, .in_target, .in_manual_value,
    .out_valid, .out_ready, .out_drive,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pid_ctl_checker chk (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_measurement, .in_target, .in_manual_value,
    .out_valid, .out_ready, .out_drive,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .n_fail, .n_pending, .n_ticks, .n_drives
  );

  // Receiver: random stall patterns, plus long hold-offs on demand.
  initial begin
    int rx_mode, run_left;
    run_left = 0;
    rx_mode = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (run_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          run_left = $urandom_range(10, 60);
        end
        run_left--;
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= BusW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stop offering requests and let every outstanding drive come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                                logic [15:0] lo, logic [15:0] hi, logic [15:0] per,
                                logic rev, logic run_auto);
    drain();
    cfg_write(REG_PROP_GAIN, kp);
    cfg_write(REG_INTEG_GAIN, ki);
    cfg_write(REG_DERIV_GAIN, kd);
    cfg_write(REG_OUT_LOW, lo);
    cfg_write(REG_OUT_HIGH, hi);
    cfg_write(REG_PERIOD_TICKS, per);
    cfg_write(REG_REVERSE_ACTING, 16'(rev));
    cfg_write(REG_AUTO_MODE, 16'(run_auto));
    settings_used++;
  endtask

  task automatic send_tick(logic [15:0] meas, logic [15:0] tgt, logic [15:0] man);
    @(negedge clk);
    in_valid <= 1'b1;
    in_measurement <= meas;
    in_target <= tgt;
    in_manual_value <= man;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_for(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_level();
    case ($urandom_range(0, 6))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 4096) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 512));
      4: return 16'($urandom_range(0, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_period();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(5, 40));
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic random_phase();
    int n_items, burst;
    logic [15:0] lo, hi, tgt, meas;
    if ($urandom_range(0, 1) == 1) begin
      drain();
      cfg_write(REG_AUTO_MODE, 16'(1'b0));
      repeat ($urandom_range(1, 4)) begin
        send_tick(rand_level(), rand_level(), rand_level());
        random_sent++;
      end
    end
    case ($urandom_range(0, 5))
      0: begin
        lo = 16'h8000;
        hi = 16'h7FFF;
      end
      1: begin
        // Inverted or equal limits: the upper limit is tested first, then the lower one.
        lo = 16'($urandom_range(0, 3000));
        hi = ($urandom_range(0, 1) == 1) ? lo : 16'(0 - $urandom_range(0, 3000));
      end
      default: begin
        lo = 16'(0 - $urandom_range(0, 20000));
        hi = 16'($urandom_range(1, 20000));
      end
    endcase
    apply_settings(rand_gain(), rand_gain(), rand_gain(), lo, hi, rand_period(),
                   1'($urandom_range(0, 1)), ($urandom_range(0, 7) != 0));
    if ($urandom_range(0, 5) == 0) hold_reqs++;
    n_items = $urandom_range(15, 45);
    while (n_items > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n_items > 0) begin
        tgt = rand_level();
        meas = ($urandom_range(0, 2) == 0) ? rand_level()
                                          : 16'(tgt + $urandom_range(0, 512) - 256);
        send_tick(meas, tgt, rand_level());
        burst--;
        n_items--;
        random_sent++;
      end
      case ($urandom_range(0, 9))
        0: drain();
        1, 2, 3: ;
        default: idle_for($urandom_range(1, 8));
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Manual hold right after reset, with the reset register values.
    send_tick(16'd100, 16'd200, 16'h7FFF);
    send_tick(16'h8000, 16'h7FFF, 16'h8000);

    // Bumpless start from a held output below the limit, zero measurements.
    apply_settings(16'd256, 16'd128, 16'd512, 16'(-2560), 16'd25600, 16'd1, 1'b0, 1'b1);
    send_tick(16'h0000, 16'd512, 16'h0000);
    send_tick(16'h0000, 16'd512, 16'h0000);
    send_tick(16'd256, 16'd512, 16'h0000);
    send_tick(16'h8000, 16'h7FFF, 16'h0000);
    send_tick(16'h7FFF, 16'h8000, 16'h0000);

    // Largest gains, reverse acting, full-range limits.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd1, 1'b1, 1'b1);
    send_tick(16'h7FFF, 16'h8000, 16'h1234);
    send_tick(16'h8000, 16'h7FFF, 16'h1234);
    send_tick(16'h0000, 16'h0000, 16'h1234);

    // Lower limit above the upper one, update on every tick.
    apply_settings(16'd300, 16'd50, 16'd20, 16'd1000, 16'(-1000), 16'd0, 1'b0, 1'b1);
    send_tick(16'd100, 16'd300, 16'h0000);
    send_tick(16'(-500), 16'd700, 16'h0000);

    // Longest period: no update follows the last one.
    apply_settings(16'd300, 16'd50, 16'd20, 16'(-2560), 16'd25600, 16'hFFFF, 1'b0, 1'b1);
    send_tick(16'd10, 16'd20, 16'h0000);
    send_tick(16'd30, 16'd20, 16'h0000);

    // Held output above the upper limit, then a bumpless start.
    drain();
    cfg_write(REG_AUTO_MODE, 16'(1'b0));
    send_tick(16'd50, 16'd60, 16'h7FFF);
    apply_settings(16'd300, 16'd50, 16'd20, 16'(-2560), 16'd25600, 16'd2, 1'b0, 1'b1);
    send_tick(16'd512, 16'd1024, 16'h0000);
    send_tick(16'd600, 16'd1024, 16'h0000);
    send_tick(16'd700, 16'd1024, 16'h0000);

    // Receiver holds off while every request needs a drive: input must back up.
    apply_settings(16'd256, 16'd16, 16'd64, 16'(-2560), 16'd25600, 16'd1, 1'b0, 1'b1);
    hold_reqs++;
    repeat (8) send_tick(rand_level(), rand_level(), rand_level());

    while (random_sent < RANDOM_TICKS) random_phase();

    drain();
    repeat (10) @(negedge clk);
    $display("Run covered %0d ticks and %0d drive results over %0d register settings,",
             n_ticks, n_drives, settings_used);
    $display("with %0d receiver hold-offs, sender drains and random stalls on both sides.",
             holds_done);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
